// File: design/pwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwb_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned VEL_W  = 16;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned BOX_W  = 12;
  localparam int unsigned CNT_W  = 4;

  // Bits of the time quotient, one per divider cycle
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned QBIT_W = $clog2(QUO_W);

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 1'b1;

  localparam logic [BOX_W-1:0] BOX_WIDTH_RST  = 12'd1600;
  localparam logic [BOX_W-1:0] BOX_HEIGHT_RST = 12'd900;

  typedef struct packed {
    logic        [POS_W-1:0]  pos_x;
    logic        [POS_W-1:0]  pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic        [TIME_W-1:0] time_step;
  } in_beat_t;

  typedef struct packed {
    logic        [POS_W-1:0] new_pos_x;
    logic        [POS_W-1:0] new_pos_y;
    logic signed [VEL_W-1:0] new_vel_x;
    logic signed [VEL_W-1:0] new_vel_y;
    logic        [CNT_W-1:0] bounce_count;
    logic                    time_dropped;
  } out_beat_t;

endpackage

`default_nettype wire

// File: design/particle_wall_bounce_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o    pwb_pkg::in_beat_t
// out       output     out_valid_o/out_stall_i  pwb_pkg::out_beat_t
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i (12 bit)
//
// One beat at a time: a sub-step computes the displacements and hit test, then for each
// wall axis hit uses the shared 16x16 multiplier and the 1-bit-per-cycle divider, and
// then moves; a beat runs sub-steps until MAX_BOUNCES bounces or its time runs out,
// and its result may wait for a stalled output.
// Reset sets the box to 1600 x 900 and empties the output register.
// A new beat is taken while a finished result waits on a stalled output.
module particle_wall_bounce_step #(
  parameter int unsigned MAX_BOUNCES = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  pwb_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output pwb_pkg::out_beat_t              out_data_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [pwb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [pwb_pkg::BOX_W-1:0]        cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_BOUNCES + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_HIT,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_DIV_LD,
    ST_DIV,
    ST_SEL,
    ST_MUL_MV,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        hit;
    logic [15:0] gap;
  } hit_t;

  function automatic logic [15:0] abs_v(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] neg_sat(logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  // Move by a magnitude and saturate to the position range
  function automatic logic [15:0] move_sat(logic [15:0] pos, logic neg, logic [15:0] mag);
    logic [16:0] s;
    if (neg) begin
      s = {1'b0, pos} - {1'b0, mag};
      return s[16] ? 16'h0000 : s[15:0];
    end else begin
      s = {1'b0, pos} + {1'b0, mag};
      return s[16] ? 16'hFFFF : s[15:0];
    end
  endfunction

  function automatic hit_t axis_hit(logic [15:0] pos, logic neg, logic [15:0] mag,
                                    logic [15:0] wall);
    hit_t        h;
    logic [16:0] s;
    s = {1'b0, pos} + {1'b0, mag};
    if (neg) begin
      h.hit = (mag != 16'd0) && (pos <= mag);
      h.gap = pos;
    end else begin
      h.hit = (mag != 16'd0) && (s >= {1'b0, wall});
      h.gap = (wall > pos) ? 16'(wall - pos) : 16'd0;
    end
    return h;
  endfunction

  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  pwb_pkg::out_beat_t      out_data_q, out_data_d;
  logic [pwb_pkg::BOX_W-1:0] box_w_q, box_w_d, box_h_q, box_h_d;

  logic        [15:0] px_q, px_d, py_q, py_d;
  logic signed [15:0] vx_q, vx_d, vy_q, vy_d;
  logic        [15:0] t_q, t_d, tm_q, tm_d;
  logic        [15:0] dxm_q, dxm_d, dym_q, dym_d;
  logic        [15:0] distx_q, distx_d, disty_q, disty_d;
  logic        [15:0] tx_q, tx_d, ty_q, ty_d;
  logic        [15:0] rem_q, rem_d, lo_q, lo_d;
  logic        [31:0] prod_q, prod_d;
  logic        [SW-1:0] cnt_q, cnt_d;
  logic        [pwb_pkg::QBIT_W-1:0] qbit_q, qbit_d;
  logic        hx_q, hx_d, hy_q, hy_d, fx_q, fx_d, fy_q, fy_d, div_y_q, div_y_d;

  logic [15:0] wall_x, wall_y, absx, absy, mul_a, mul_b, dmag, rem_n, lo_n, t_new;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [SW-1:0] cnt_nx;
  hit_t        hit_x, hit_y;
  logic        in_acc, out_free;

  assign wall_x = {box_w_q, 4'b0000};
  assign wall_y = {box_h_q, 4'b0000};
  assign absx   = abs_v(vx_q);
  assign absy   = abs_v(vy_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL_X:  begin mul_a = absx;    mul_b = t_q;  end
      ST_MUL_Y:  begin mul_a = absy;    mul_b = t_q;  end
      ST_MUL_DX: begin mul_a = distx_q; mul_b = t_q;  end
      ST_MUL_DY: begin mul_a = disty_q; mul_b = t_q;  end
      ST_MUL_MV: begin mul_a = fx_q ? absy : absx; mul_b = tm_q; end
      default:   begin mul_a = 16'd0;   mul_b = 16'd0; end
    endcase
  end

  // Restoring divider step, one quotient bit per cycle
  assign dmag   = div_y_q ? dym_q : dxm_q;
  assign div_sh = {rem_q, lo_q[15]};
  assign div_ge = (div_sh >= {1'b0, dmag});
  assign rem_n  = div_ge ? 16'(div_sh - {1'b0, dmag}) : div_sh[15:0];
  assign lo_n   = {lo_q[14:0], div_ge};

  assign hit_x  = axis_hit(px_q, vx_q[15], dxm_q, wall_x);
  assign hit_y  = axis_hit(py_q, vy_q[15], prod_q[31:16], wall_y);
  assign cnt_nx = cnt_q + SW'(1);
  assign t_new  = t_q - tm_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    box_w_d     = box_w_q;
    box_h_d     = box_h_q;
    px_d = px_q;  py_d = py_q;  vx_d = vx_q;  vy_d = vy_q;
    t_d  = t_q;   tm_d = tm_q;  dxm_d = dxm_q; dym_d = dym_q;
    distx_d = distx_q; disty_d = disty_q; tx_d = tx_q; ty_d = ty_q;
    rem_d = rem_q; lo_d = lo_q; prod_d = prod_q; cnt_d = cnt_q; qbit_d = qbit_q;
    hx_d = hx_q; hy_d = hy_q; fx_d = fx_q; fy_d = fy_q; div_y_d = div_y_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwb_pkg::CFG_BOX_WIDTH:  box_w_d = cfg_data_i;
        pwb_pkg::CFG_BOX_HEIGHT: box_h_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          px_d  = in_data_i.pos_x;
          py_d  = in_data_i.pos_y;
          vx_d  = in_data_i.vel_x;
          vy_d  = in_data_i.vel_y;
          t_d   = in_data_i.time_step;
          cnt_d = '0;
          state_d = (in_data_i.time_step == 16'd0) ? ST_FIN : ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        dxm_d   = prod_q[31:16];
        prod_d  = mul_a * mul_b;
        state_d = ST_HIT;
      end
      ST_HIT: begin
        dym_d   = prod_q[31:16];
        hx_d    = hit_x.hit;
        hy_d    = hit_y.hit;
        distx_d = hit_x.gap;
        disty_d = hit_y.gap;
        div_y_d = !hit_x.hit;
        if (!hit_x.hit && !hit_y.hit) begin
          // no wall within reach: spend all remaining time
          px_d    = move_sat(px_q, vx_q[15], dxm_q);
          py_d    = move_sat(py_q, vy_q[15], prod_q[31:16]);
          t_d     = 16'd0;
          state_d = ST_FIN;
        end else begin
          state_d = hit_x.hit ? ST_MUL_DX : ST_MUL_DY;
        end
      end
      ST_MUL_DX: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_DIV_LD;
      end
      ST_MUL_DY: begin
        prod_d  = mul_a * mul_b;
        div_y_d = 1'b1;
        state_d = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        rem_d   = prod_q[31:16];
        lo_d    = prod_q[15:0];
        qbit_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = rem_n;
        lo_d   = lo_n;
        qbit_d = qbit_q + pwb_pkg::QBIT_W'(1);
        if (qbit_q == pwb_pkg::QBIT_W'(pwb_pkg::QUO_W - 1)) begin
          if (div_y_q) begin
            ty_d    = lo_n;
            state_d = ST_SEL;
          end else begin
            tx_d    = lo_n;
            state_d = hy_q ? ST_MUL_DY : ST_SEL;
          end
        end
      end
      ST_SEL: begin
        if (hx_q && hy_q) begin
          tm_d = (tx_q < ty_q) ? tx_q : ty_q;
          fx_d = (tx_q <= ty_q);
          fy_d = (ty_q <= tx_q);
        end else begin
          tm_d = hx_q ? tx_q : ty_q;
          fx_d = hx_q;
          fy_d = hy_q;
        end
        state_d = (hx_q && hy_q && (tx_q == ty_q)) ? ST_UPD : ST_MUL_MV;
      end
      ST_MUL_MV: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // reflecting axis lands on its wall, the other moves for the hit time
        px_d = fx_q ? (vx_q[15] ? 16'd0 : wall_x) : move_sat(px_q, vx_q[15], prod_q[31:16]);
        py_d = fy_q ? (vy_q[15] ? 16'd0 : wall_y) : move_sat(py_q, vy_q[15], prod_q[31:16]);
        if (fx_q) vx_d = neg_sat(vx_q);
        if (fy_q) vy_d = neg_sat(vy_q);
        t_d     = t_new;
        cnt_d   = cnt_nx;
        state_d = ((cnt_nx < SW'(MAX_BOUNCES)) && (t_new != 16'd0)) ? ST_MUL_X : ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.new_pos_x    = px_q;
          out_data_d.new_pos_y    = py_q;
          out_data_d.new_vel_x    = vx_q;
          out_data_d.new_vel_y    = vy_q;
          out_data_d.bounce_count = (32'(cnt_q) > 32'd15) ? 4'hF : 4'(cnt_q);
          out_data_d.time_dropped = (t_q != 16'd0);
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      box_w_q     <= pwb_pkg::BOX_WIDTH_RST;
      box_h_q     <= pwb_pkg::BOX_HEIGHT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      box_w_q     <= box_w_d;
      box_h_q     <= box_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  vx_q <= vx_d;  vy_q <= vy_d;
    t_q  <= t_d;   tm_q <= tm_d;  dxm_q <= dxm_d; dym_q <= dym_d;
    distx_q <= distx_d; disty_q <= disty_d; tx_q <= tx_d; ty_q <= ty_d;
    rem_q <= rem_d; lo_q <= lo_d; prod_q <= prod_d; cnt_q <= cnt_d; qbit_q <= qbit_d;
    hx_q <= hx_d; hy_q <= hy_d; fx_q <= fx_d; fy_q <= fy_d; div_y_q <= div_y_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted beat did not start work");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> dmag != 16'd0)
    else $error("divider started with zero displacement");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < dmag)
    else $error("divider remainder out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.bounce_count) <= 32'(MAX_BOUNCES))
    else $error("bounce count above limit");
`endif

endmodule

`default_nettype wire
